// ----- rtl/core/mdio_mfm_pkg.sv -----
// ----------------------------------------------------------------------------
// mdio_mfm_pkg
// Shared types and constants of the MDIO management frame master.
// ----------------------------------------------------------------------------
`default_nettype none

package mdio_mfm_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_PREAMBLE = 1'b0;
  localparam logic REG_PHASE    = 1'b1;

  localparam int          PADDR_W        = 3;
  localparam logic [5:0]  PREAMBLE_MAX   = 6'd32;
  localparam logic [5:0]  PREAMBLE_RESET = 6'd32;
  localparam logic [9:0]  PHASE_RESET    = 10'd50;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  phy_address;
    logic [4:0]  register_address;
    logic [15:0] write_data;
    logic        mdio_in;
  } cmd_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_oe;
    logic        mdio_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        start_ignored;
  } res_t;

  typedef struct packed {
    logic [5:0] preamble_bits;
    logic [9:0] phase_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/mdio_management_frame_master.sv -----
// ----------------------------------------------------------------------------
// mdio_management_frame_master
// Clause 22 MDIO management master driven one tick per request.
// ----------------------------------------------------------------------------
// Each accepted request is one tick of the management interface: it may start
// a read or write frame and carries the sampled MDIO level. Each request gives
// exactly one result with the MDC/MDIO levels for that tick, busy/done status
// and the last read value. One request is taken every clock cycle unless
// stalled; the tick sequencer updates in that cycle and the result lands in
// an output register, so a new request is accepted while the previous result
// waits, as long as that result is taken in the same cycle. preamble_bits
// (address 0) and phase_ticks (address 4) are set over the APB port.
`default_nettype none

module mdio_management_frame_master
  import mdio_mfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res_comb;
  logic step;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cmd_ready = !res_valid || res_ready;
  assign step      = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_bits <= PREAMBLE_RESET;
      cfg.phase_ticks   <= PHASE_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PREAMBLE: cfg.preamble_bits <= pwdata[5:0];
        REG_PHASE:    cfg.phase_ticks   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PREAMBLE: prdata = {26'd0, cfg.preamble_bits};
      REG_PHASE:    prdata = {22'd0, cfg.phase_ticks};
      default:      prdata = 32'd0;
    endcase
  end

  mdio_mfm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_comb;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mdio_mfm_seq.sv -----
// ----------------------------------------------------------------------------
// mdio_mfm_seq
// Frame sequencer: advances one tick per step and forms that tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_mfm_seq
  import mdio_mfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res
);

  logic        active,        active_next;
  logic        is_read,       is_read_next;
  logic [6:0]  bit_position,  bit_position_next;
  logic [1:0]  bit_phase,     bit_phase_next;
  logic [9:0]  phase_count,   phase_count_next;
  logic [4:0]  held_phy,      held_phy_next;
  logic [4:0]  held_register, held_register_next;
  logic [15:0] held_value,    held_value_next;
  logic [15:0] capture_shift, capture_shift_next;
  logic [15:0] last_read,     last_read_next;

  logic        is_start_cmd;
  logic        start;
  logic [5:0]  pre_eff;
  logic [9:0]  phase_eff;
  logic [6:0]  frame_len;
  logic [6:0]  k;
  logic [2:0]  phy_idx;
  logic [2:0]  reg_idx;
  logic [3:0]  val_idx;
  logic [10:0] count_inc;
  logic        last;
  logic        drive;
  logic        level;
  logic        sampled;
  logic [1:0]  phase_inc;

  assign is_start_cmd = (cmd.command == CMD_READ) || (cmd.command == CMD_WRITE);
  assign start        = is_start_cmd && !active;
  assign pre_eff      = (cfg.preamble_bits > PREAMBLE_MAX) ? PREAMBLE_MAX : cfg.preamble_bits;
  assign phase_eff    = (cfg.phase_ticks == 10'd0) ? 10'd1 : cfg.phase_ticks;

  // state as seen after a start has been taken in this tick
  always_comb begin
    active_next        = active || start;
    is_read_next       = start ? (cmd.command == CMD_READ) : is_read;
    bit_position_next  = start ? 7'd0 : bit_position;
    bit_phase_next     = start ? 2'd0 : bit_phase;
    phase_count_next   = start ? 10'd0 : phase_count;
    held_phy_next      = start ? cmd.phy_address : held_phy;
    held_register_next = start ? cmd.register_address : held_register;
    held_value_next    = start ? cmd.write_data : held_value;
    capture_shift_next = start ? 16'd0 : capture_shift;
    last_read_next     = last_read;

    frame_len = {1'b0, pre_eff} + (is_read_next ? 7'd31 : 7'd32);
    k         = bit_position_next - {1'b0, pre_eff};
    phy_idx   = 3'(7'd8 - k);
    reg_idx   = 3'(7'd13 - k);
    val_idx   = 4'(7'd31 - k);
    count_inc = {1'b0, phase_count_next} + 11'd1;
    last      = count_inc >= {1'b0, phase_eff};
    phase_inc = bit_phase_next + 2'd1;

    drive   = 1'b1;
    level   = 1'b1;
    sampled = 1'b0;
    if (bit_position_next >= {1'b0, pre_eff}) begin
      if (k == 7'd0) begin
        level = 1'b0;
      end else if (k == 7'd1) begin
        level = 1'b1;
      end else if (k == 7'd2) begin
        level = is_read_next;
      end else if (k == 7'd3) begin
        level = !is_read_next;
      end else if (k <= 7'd8) begin
        level = held_phy_next[phy_idx];
      end else if (k <= 7'd13) begin
        level = held_register_next[reg_idx];
      end else if (is_read_next) begin
        // turnaround and data of a read: line released
        drive   = 1'b0;
        level   = 1'b0;
        sampled = (k >= 7'd15) && (k <= 7'd30);
      end else if (k == 7'd14) begin
        level = 1'b1;
      end else if (k == 7'd15) begin
        level = 1'b0;
      end else if (k <= 7'd31) begin
        level = held_value_next[val_idx];
      end else begin
        level = 1'b0;
      end
    end

    res               = '0;
    res.start_ignored = is_start_cmd && active;

    if (active_next) begin
      if (bit_position_next >= frame_len) begin
        // completion tick
        active_next       = 1'b0;
        res.done_res      = 1'b1;
        if (is_read_next) begin
          last_read_next = capture_shift_next;
        end
        bit_position_next = 7'd0;
        bit_phase_next    = 2'd0;
        phase_count_next  = 10'd0;
      end else begin
        res.mdc        = (bit_phase_next == 2'd1);
        res.mdio_oe    = drive;
        res.mdio_level = drive && level;
        if (sampled && (bit_phase_next == 2'd1) && last) begin
          capture_shift_next = {capture_shift_next[14:0], cmd.mdio_in};
        end
        if (last) begin
          phase_count_next = 10'd0;
          if (phase_inc >= 2'd3) begin
            bit_phase_next    = 2'd0;
            bit_position_next = bit_position_next + 7'd1;
          end else begin
            bit_phase_next = phase_inc;
          end
        end else begin
          phase_count_next = count_inc[9:0];
        end
      end
    end

    res.busy_res  = active_next;
    res.read_data = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      is_read      <= 1'b0;
      bit_position <= 7'd0;
      bit_phase    <= 2'd0;
      phase_count  <= 10'd0;
      last_read    <= 16'd0;
    end else if (step) begin
      active       <= active_next;
      is_read      <= is_read_next;
      bit_position <= bit_position_next;
      bit_phase    <= bit_phase_next;
      phase_count  <= phase_count_next;
      last_read    <= last_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_phy      <= held_phy_next;
      held_register <= held_register_next;
      held_value    <= held_value_next;
      capture_shift <= capture_shift_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mdio_mfm_checker.sv -----
// ----------------------------------------------------------------------------
// mdio_mfm_checker
// Port-level checks of the MDIO management frame master.
// ----------------------------------------------------------------------------
`default_nettype none

module mdio_mfm_checker
  import mdio_mfm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_ready,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res
);

  // a held result stays put until taken
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // with the output register empty a request is always taken
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("request refused with empty output register");

  // the completion tick ends the frame and drives nothing
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |->
      !res.busy_res && !res.mdc && !res.mdio_oe && !res.mdio_level)
    else $error("completion tick not quiet");

  // outside a frame the lines are idle
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.busy_res && !res.done_res |->
      !res.mdc && !res.mdio_oe && !res.mdio_level)
    else $error("line activity while idle");

endmodule

bind mdio_management_frame_master mdio_mfm_checker u_checker (.*);

`default_nettype wire
